// ----- hdl/spe_pkg.sv -----
// Shared types and constants of the postfix stack evaluator.
`default_nettype none

package spe_pkg;

  // Data word and result field widths.
  localparam int DATA_W = 32;
  localparam int OPCODE_W = 3;
  localparam int DEPTH_W = 6;
  localparam int STATUS_W = 2;

  // Default number of stack cells and the most entries one dump returns.
  localparam int DEFAULT_STACK_DEPTH = 32;
  localparam int MAX_OUT = 32;

  // Token opcodes.
  localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DUMP = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  // Stack cell moves: keep, take from the cell above, take from the cell below.
  localparam int CELL_MODE_W = 2;
  localparam logic [CELL_MODE_W-1:0] CELL_HOLD = 2'd0;
  localparam logic [CELL_MODE_W-1:0] CELL_DOWN = 2'd1;
  localparam logic [CELL_MODE_W-1:0] CELL_UP   = 2'd2;

  // One input token.
  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [DATA_W-1:0] operand_value;
  } token_t;

  // One result item.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [STATUS_W-1:0]      status;
    logic                     last_result;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/spe_cell.sv -----
// One stack cell: holds one entry and moves it to or from its neighbors.
`default_nettype none

module spe_cell
  import spe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [CELL_MODE_W-1:0] mode,
  input  wire logic [DATA_W-1:0]      data_above,
  input  wire logic [DATA_W-1:0]      data_below,
  output logic [DATA_W-1:0]           data
);

  // Entry register; the mode picks which neighbor it takes from.
  always_ff @(posedge clk) begin
    case (mode)
      CELL_DOWN: data <= data_above;
      CELL_UP:   data <= data_below;
      default:   data <= data;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/spe_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module spe_div
  import spe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  localparam int ITER_W = $clog2(DATA_W);

  logic              busy;
  logic [ITER_W-1:0] count;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;

  logic              dividend_neg;
  logic              divisor_neg;
  logic [DATA_W-1:0] dividend_mag;
  logic [DATA_W-1:0] divisor_mag;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // Magnitudes and sign of the operands.
  always_comb begin
    dividend_neg = dividend[DATA_W-1];
    divisor_neg  = divisor[DATA_W-1];
    dividend_mag = dividend_neg ? (DATA_W'(0) - dividend) : dividend;
    divisor_mag  = divisor_neg ? (DATA_W'(0) - divisor) : divisor;
  end

  // Restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
      rem   <= '0;
      quo   <= dividend_mag;
      dvs   <= divisor_mag;
      neg   <= dividend_neg ^ divisor_neg;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
      count <= count + ITER_W'(1);
      if (count == ITER_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Apply the sign of the quotient.
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

endmodule

`default_nettype wire

// ----- hdl/postfix_stack_evaluator.sv -----
// Top level of the postfix stack evaluator: control, stack cells, ALU and divider.
`default_nettype none

// Evaluates postfix tokens one at a time on a stack built as a row of
// STACK_DEPTH cells, where cell 0 is the top and every push, pop or rotation
// moves all entries by one cell at once. A push or an ignored opcode passes
// from the idle state through the execute state; add, subtract and multiply
// then also pass the apply state, and divide waits in the divide-wait state
// for the divider, which produces one quotient bit per cycle, before the apply
// state. A dump of a non-empty stack rotates the whole cell row once around,
// waiting while the result side stalls, and leaves the stack as it found it. A
// result waits in an output register, and the next token is taken while it
// waits. Errors leave the stack unchanged and are reported in the status field
// of the single result.
module postfix_stack_evaluator
  import spe_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    token_valid,
  output logic         token_ready,
  input  wire token_t  token,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W = $clog2(STACK_DEPTH);
  localparam int N_W   = 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIVW  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;

  logic [2:0]          state, state_next;
  logic [SP_W-1:0]     sp, sp_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [OPCODE_W-1:0] opcode;
  logic [DATA_W-1:0]   operand;
  logic [DATA_W-1:0]   alu_res, alu_res_next;
  logic                alu_load;

  logic [CELL_MODE_W-1:0] mode_top, mode_rest;
  logic [DATA_W-1:0]      load_val;
  logic [DATA_W-1:0]      cell_data [STACK_DEPTH];

  logic                out_free;
  logic                out_load;
  result_t             result_next;

  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_quotient;

  logic [DATA_W-1:0]   right;
  logic [DATA_W-1:0]   left;
  logic [DATA_W-1:0]   top;
  logic [DATA_W-1:0]   alu_out;
  logic [N_W-1:0]      dump_n;
  logic                dump_emit;

  // Row of stack cells; the top takes load_val, the bottom wraps to the top.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = load_val;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_data[0];
    end else begin : g_up
      assign below = cell_data[i+1];
    end
    spe_cell u_cell (
      .clk        (clk),
      .mode       ((i == 0) ? mode_top : mode_rest),
      .data_above (above),
      .data_below (below),
      .data       (cell_data[i])
    );
  end

  spe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left),
    .divisor  (right),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Operands and add, subtract, multiply on the two top cells.
  always_comb begin
    right = cell_data[0];
    left  = cell_data[1];
    top   = (sp == '0) ? '0 : cell_data[0];
    case (opcode)
      OP_ADD:  alu_out = left + right;
      OP_SUB:  alu_out = left - right;
      default: alu_out = left * right;
    endcase
  end

  // Number of entries a dump returns and whether this rotation step emits one.
  always_comb begin
    dump_n    = (N_W'(sp) > N_W'(MAX_OUT)) ? N_W'(MAX_OUT) : N_W'(sp);
    dump_emit = N_W'(cnt) < dump_n;
  end

  assign out_free    = !result_valid || result_ready;
  assign token_ready = (state == S_IDLE) && !rst;

  // Sequencer for one token.
  always_comb begin
    state_next   = state;
    sp_next      = sp;
    cnt_next     = cnt;
    mode_top     = CELL_HOLD;
    mode_rest    = CELL_HOLD;
    load_val     = operand;
    out_load     = 1'b0;
    result_next  = '{value: top, stack_depth: DEPTH_W'(sp), status: ST_OK,
                     last_result: 1'b1};
    div_start    = 1'b0;
    alu_load     = 1'b0;
    alu_res_next = alu_out;
    case (state)
      S_IDLE: begin
        if (token_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (opcode)
          OP_PUSH: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = S_IDLE;
              if (sp == SP_W'(STACK_DEPTH)) begin
                result_next.status = ST_OVER;
              end else begin
                mode_top                = CELL_DOWN;
                mode_rest               = CELL_DOWN;
                sp_next                 = sp + SP_W'(1);
                result_next.value       = operand;
                result_next.stack_depth = DEPTH_W'(sp + SP_W'(1));
              end
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (sp < SP_W'(2)) begin
              if (out_free) begin
                out_load           = 1'b1;
                result_next.status = ST_UNDER;
                state_next         = S_IDLE;
              end
            end else if (opcode == OP_DIV) begin
              if (right == '0) begin
                if (out_free) begin
                  out_load           = 1'b1;
                  result_next.status = ST_DIVZ;
                  state_next         = S_IDLE;
                end
              end else begin
                div_start  = 1'b1;
                state_next = S_DIVW;
              end
            end else begin
              alu_load   = 1'b1;
              state_next = S_APPLY;
            end
          end
          OP_DUMP: begin
            if (sp == '0) begin
              if (out_free) begin
                out_load   = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              cnt_next   = '0;
              state_next = S_DUMP;
            end
          end
          default: begin
            // Unused opcodes report the current top and depth.
            if (out_free) begin
              out_load   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_DIVW: begin
        if (div_done) begin
          alu_load     = 1'b1;
          alu_res_next = div_quotient;
          state_next   = S_APPLY;
        end
      end
      S_APPLY: begin
        // Pop both operands and push the result in one move of the row.
        if (out_free) begin
          mode_top                = CELL_DOWN;
          mode_rest               = CELL_UP;
          load_val                = alu_res;
          sp_next                 = sp - SP_W'(1);
          out_load                = 1'b1;
          result_next.value       = alu_res;
          result_next.stack_depth = DEPTH_W'(sp - SP_W'(1));
          state_next              = S_IDLE;
        end
      end
      S_DUMP: begin
        // Rotate the row once around, emitting the top entry until dump_n entries are out.
        if (!dump_emit || out_free) begin
          mode_top  = CELL_UP;
          mode_rest = CELL_UP;
          if (dump_emit) begin
            out_load                = 1'b1;
            result_next.value       = cell_data[0];
            result_next.last_result = (N_W'(cnt) + N_W'(1)) == dump_n;
          end
          if (cnt == CNT_W'(STACK_DEPTH - 1)) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      cnt   <= cnt_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Token capture, ALU result and output item registers.
  always_ff @(posedge clk) begin
    if (token_valid && token_ready) begin
      opcode  <= token.opcode;
      operand <= token.operand_value;
    end
    if (alu_load) begin
      alu_res <= alu_res_next;
    end
    if (out_load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_postfix_stack_evaluator.sv -----
// Self-checking testbench of the postfix stack evaluator with a stack predictor and random stalls.
`default_nettype none

module tb_postfix_stack_evaluator;
  import spe_pkg::*;

  localparam int STACK_CELLS = DEFAULT_STACK_DEPTH;
  // Opcodes the block leaves undecoded; it answers them with the current top.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  // Receiver hold-off of the back-pressure test, and the watchdog limit on quiet cycles.
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    token_valid = 1'b0;
  logic    token_ready;
  token_t  token = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Shadow copy of the stack and the results it predicts, oldest first.
  logic [DATA_W-1:0] shadow_stack [STACK_CELLS];
  int                shadow_depth = 0;
  result_t           pending_results [$];

  int  mismatch_count = 0;
  int  tokens_counted = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_CELLS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #5 clk = ~clk;

  function automatic result_t make_result(input logic [DATA_W-1:0] v, input int depth,
                                          input logic [STATUS_W-1:0] s, input logic last);
    result_t r;
    r.value = v;
    r.stack_depth = DEPTH_W'(depth);
    r.status = s;
    r.last_result = last;
    return r;
  endfunction

  // Signed division that truncates toward zero; the most negative number over minus one wraps.
  function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] dividend,
                                                             input logic [DATA_W-1:0] divisor);
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] q;
    mag_a = dividend[DATA_W-1] ? -dividend : dividend;
    mag_b = divisor[DATA_W-1] ? -divisor : divisor;
    q = mag_a / mag_b;
    return (dividend[DATA_W-1] != divisor[DATA_W-1]) ? -q : q;
  endfunction

  // Applies one accepted token to the shadow stack and queues the results it causes.
  function automatic void evaluate_token(input token_t t);
    logic [DATA_W-1:0]   left;
    logic [DATA_W-1:0]   right;
    logic [DATA_W-1:0]   outcome;
    logic [STATUS_W-1:0] status;
    int                  shown;
    status = ST_OK;
    outcome = '0;
    case (t.opcode)
      OP_DUMP: begin
        if (shadow_depth == 0) begin
          pending_results.push_back(make_result('0, 0, ST_OK, 1'b1));
        end else begin
          shown = (shadow_depth > MAX_OUT) ? MAX_OUT : shadow_depth;
          for (int i = 0; i < shown; i++) begin
            pending_results.push_back(make_result(shadow_stack[shadow_depth - 1 - i],
                                                  shadow_depth, ST_OK, i == shown - 1));
          end
        end
        return;
      end
      OP_PUSH: begin
        if (shadow_depth >= STACK_CELLS) begin
          status = ST_OVER;
        end else begin
          shadow_stack[shadow_depth] = t.operand_value;
          shadow_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (shadow_depth < 2) begin
          status = ST_UNDER;
        end else begin
          right = shadow_stack[shadow_depth - 1];
          left = shadow_stack[shadow_depth - 2];
          case (t.opcode)
            OP_ADD: outcome = left + right;
            OP_SUB: outcome = left - right;
            OP_MUL: outcome = left * right;
            default: begin
              if (right == '0) status = ST_DIVZ;
              else outcome = quotient_toward_zero(left, right);
            end
          endcase
          if (status == ST_OK) begin
            shadow_stack[shadow_depth - 2] = outcome;
            shadow_depth--;
          end
        end
      end
      default: ;
    endcase
    pending_results.push_back(make_result((shadow_depth == 0) ? '0 :
                                          shadow_stack[shadow_depth - 1],
                                          shadow_depth, status, 1'b1));
  endfunction

  // Operand values lean toward the extremes and small numbers so divisions give real quotients.
  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5, 6: return DATA_W'($urandom_range(32)) - 32'd16;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] random_operator();
    case ($urandom_range(3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Offers one item, holds it until accepted, then updates the prediction.
  task automatic send_token(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] v);
    token_t t;
    t.opcode = op;
    t.operand_value = v;
    if (sender_idles) begin
      while ($urandom_range(99) < 30) begin
        token_valid <= 1'b0;
        @(posedge clk);
      end
    end
    token_valid <= 1'b1;
    token <= t;
    do @(posedge clk); while (token_ready !== 1'b1);
    evaluate_token(t);
    if (op != OP_SPARE_LO && op != OP_SPARE_HI) tokens_counted++;
  endtask

  task automatic push_value(input logic [DATA_W-1:0] v);
    send_token(OP_PUSH, v);
  endtask

  // Operators carry a random operand, which the block must ignore.
  task automatic apply_operator(input logic [OPCODE_W-1:0] op);
    send_token(op, $urandom());
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compares one accepted result with the oldest prediction.
  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result item: value %0d, stack_depth %0d", got.value, got.stack_depth);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.value !== want.value) begin
      $error("value: expected %0d, actual %0d", want.value, got.value);
      mismatch_count++;
    end
    if (got.stack_depth !== want.stack_depth) begin
      $error("stack_depth: expected %0d, actual %0d", want.stack_depth, got.stack_depth);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.last_result !== want.last_result) begin
      $error("last_result: expected %0d, actual %0d", want.last_result, got.last_result);
      mismatch_count++;
    end
  endtask

  // Result side: check each accepted item, then choose ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready) check_result(result);
    if (hold_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (receiver_idles) begin
      result_ready <= ($urandom_range(99) >= 30);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any accepted item on either side ends the run.
  always @(posedge clk) begin
    if ((token_valid && token_ready === 1'b1) || (result_valid === 1'b1 && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("postfix_stack_evaluator verification failed");
      $finish;
    end
  end

  // Empty stack right after reset: dump, underflow and the undecoded opcodes.
  task automatic test_empty_stack();
    send_token(OP_DUMP, $urandom());
    apply_operator(OP_ADD);
    send_token(OP_SPARE_LO, $urandom());
    send_token(OP_SPARE_HI, $urandom());
  endtask

  // Wrapping arithmetic, division rounding and division by zero.
  task automatic test_arithmetic_edges();
    push_value(32'h7FFF_FFFF);
    push_value(32'd1);
    apply_operator(OP_ADD);
    push_value('1);
    apply_operator(OP_DIV);
    push_value('0);
    apply_operator(OP_DIV);
    apply_operator(OP_SUB);
    push_value(-32'd7);
    push_value(32'd2);
    apply_operator(OP_DIV);
    apply_operator(OP_MUL);
    push_value(32'h7FFF_FFFF);
    apply_operator(OP_MUL);
    push_value(32'h8000_0000);
    push_value(32'd1);
    apply_operator(OP_SUB);
    push_value(32'd7);
    apply_operator(OP_DIV);
    send_token(OP_DUMP, $urandom());
  endtask

  // Fill to the last cell, push once more, dump all entries, fold back to one entry, then underflow and dump.
  task automatic test_full_stack();
    while (shadow_depth < STACK_CELLS) push_value(random_operand());
    push_value(random_operand());
    send_token(OP_DUMP, $urandom());
    while (shadow_depth > 1) apply_operator(random_operator());
    apply_operator(OP_SUB);
    send_token(OP_DUMP, $urandom());
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 10; i++) push_value(random_operand());
    apply_operator(OP_DIV);
    send_token(OP_DUMP, $urandom());
    for (int i = 0; i < 9; i++) apply_operator(random_operator());
    sender_idles = 1'b1;
  endtask

  // One random postfix expression, with a fold-down when the stack runs deep.
  task automatic run_expression();
    int operands;
    while (shadow_depth > 20) apply_operator(OP_ADD);
    operands = $urandom_range(2, 5);
    for (int i = 0; i < operands; i++) push_value(random_operand());
    for (int i = 0; i < operands - 1; i++) apply_operator(random_operator());
    if ($urandom_range(3) == 0) begin
      while (shadow_depth > 1) apply_operator(random_operator());
    end
  endtask

  // Mostly well-formed expressions, some dumps, and raw tokens of any opcode.
  task automatic test_random_tokens(input int count);
    int goal;
    int pick;
    goal = tokens_counted + count;
    while (tokens_counted < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) run_expression();
      else if (pick < 85) send_token(OP_DUMP, $urandom());
      else send_token(OPCODE_W'($urandom()), $urandom());
    end
  endtask

  // Random tokens with neither side idling.
  task automatic test_back_to_back();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_tokens(60);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_arithmetic_edges();
    test_full_stack();
    test_output_backpressure();
    test_random_tokens(190);
    test_back_to_back();
    token_valid <= 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("postfix_stack_evaluator verification clean");
    end else begin
      $display("postfix_stack_evaluator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- postfix_stack_evaluator.f -----
hdl/spe_pkg.sv
hdl/spe_cell.sv
hdl/spe_div.sv
hdl/postfix_stack_evaluator.sv
bench/tb_postfix_stack_evaluator.sv
